FILE: src/rtn_pkg.sv
// Shared types, constants and symbol tables for the Roman numeral converter.
package rtn_pkg;

  // Input value and decimal digit widths
  typedef logic [11:0] value_t;
  typedef logic [3:0]  digit_t;
  typedef logic [1:0]  place_t;

  localparam value_t ValueLimit = 12'd4000;

  // ASCII codes of the numeral symbols
  localparam logic [7:0] CharM    = 8'h4D;
  localparam logic [7:0] CharD    = 8'h44;
  localparam logic [7:0] CharC    = 8'h43;
  localparam logic [7:0] CharL    = 8'h4C;
  localparam logic [7:0] CharX    = 8'h58;
  localparam logic [7:0] CharV    = 8'h56;
  localparam logic [7:0] CharI    = 8'h49;
  localparam logic [7:0] CharNull = 8'h00;

  // Decimal places, thousands down to ones
  localparam place_t PlaceOnes      = 2'd0;
  localparam place_t PlaceTens      = 2'd1;
  localparam place_t PlaceHundreds  = 2'd2;
  localparam place_t PlaceThousands = 2'd3;

  // Role of a symbol inside one decimal place: unit, five or next unit up
  typedef enum logic [1:0] {
    SYM_ONE  = 2'd0,
    SYM_FIVE = 2'd1,
    SYM_TEN  = 2'd2
  } sym_role_t;

  // Symbol sequence of one decimal digit, role[0] is emitted first
  typedef struct packed {
    logic [2:0]           len;
    sym_role_t [3:0]      role;
  } pattern_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic                invalid;
    digit_t [3:0]        digits;
  } rtn_entry_t;

  // Weight of one decimal place
  function automatic value_t place_weight(place_t place);
    value_t w;
    unique case (place)
      PlaceThousands: w = 12'd1000;
      PlaceHundreds:  w = 12'd100;
      PlaceTens:      w = 12'd10;
      PlaceOnes:      w = 12'd1;
      default:        w = 12'd1;
    endcase
    return w;
  endfunction

  // Symbol roles of one digit in additive and subtractive form
  function automatic pattern_t digit_pattern(digit_t d);
    pattern_t p;
    p.role = '{default: SYM_ONE};
    p.len  = 3'd0;
    unique case (d)
      4'd0: p.len = 3'd0;
      4'd1: p.len = 3'd1;
      4'd2: p.len = 3'd2;
      4'd3: p.len = 3'd3;
      4'd4: begin
        p.len     = 3'd2;
        p.role[1] = SYM_FIVE;
      end
      4'd5: begin
        p.len     = 3'd1;
        p.role[0] = SYM_FIVE;
      end
      4'd6: begin
        p.len     = 3'd2;
        p.role[0] = SYM_FIVE;
      end
      4'd7: begin
        p.len     = 3'd3;
        p.role[0] = SYM_FIVE;
      end
      4'd8: begin
        p.len     = 3'd4;
        p.role[0] = SYM_FIVE;
      end
      4'd9: begin
        p.len     = 3'd2;
        p.role[1] = SYM_TEN;
      end
      default: p.len = 3'd0;
    endcase
    return p;
  endfunction

  // ASCII character of a role within a decimal place
  function automatic logic [7:0] place_char(place_t place, sym_role_t role);
    logic [7:0] c;
    c = CharNull;
    unique case (place)
      PlaceThousands: c = CharM;
      PlaceHundreds: begin
        unique case (role)
          SYM_ONE:  c = CharC;
          SYM_FIVE: c = CharD;
          SYM_TEN:  c = CharM;
          default:  c = CharNull;
        endcase
      end
      PlaceTens: begin
        unique case (role)
          SYM_ONE:  c = CharX;
          SYM_FIVE: c = CharL;
          SYM_TEN:  c = CharC;
          default:  c = CharNull;
        endcase
      end
      PlaceOnes: begin
        unique case (role)
          SYM_ONE:  c = CharI;
          SYM_FIVE: c = CharV;
          SYM_TEN:  c = CharX;
          default:  c = CharNull;
        endcase
      end
      default: c = CharNull;
    endcase
    return c;
  endfunction

endpackage

FILE: src/rtn_front.sv
// Front end: accepts a value, range-checks it and splits it into decimal digits.
module rtn_front import rtn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  value_t     in_value,
  output logic       push_valid,
  input  logic       push_ready,
  output rtn_entry_t push_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;
  value_t       rem_r, rem_nxt;
  place_t       place_r, place_nxt;
  rtn_entry_t   entry_r, entry_nxt;
  digit_t       digit;
  value_t       weight;
  value_t       sub;

  // Find the digit of the current place by compares against its multiples
  always_comb begin
    weight = place_weight(place_r);
    digit  = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem_r} >= 14'(k) * {2'b00, weight}) begin
        digit = digit_t'(k);
      end
    end
    sub = 12'({8'd0, digit} * weight);
  end

  // Sequence accept, digit extraction and hand-off to the queue
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    place_nxt = place_r;
    entry_nxt = entry_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          entry_nxt.digits = '0;
          rem_nxt          = in_value;
          place_nxt        = PlaceThousands;
          if (in_value == '0 || in_value >= ValueLimit) begin
            entry_nxt.invalid = 1'b1;
            state_nxt         = F_PUSH;
          end else begin
            entry_nxt.invalid = 1'b0;
            state_nxt         = F_CONV;
          end
        end
      end
      F_CONV: begin
        entry_nxt.digits[place_r] = digit;
        rem_nxt                   = rem_r - sub;
        if (place_r == PlaceOnes) begin
          state_nxt = F_PUSH;
        end else begin
          place_nxt = place_r - 2'd1;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    place_r <= place_nxt;
    entry_r <= entry_nxt;
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = entry_r;

endmodule

FILE: src/rtn_queue.sv
// Small register queue between the front and back ends.
module rtn_queue import rtn_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  rtn_entry_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output rtn_entry_t pop_data
);

  // Depth is a power of two, at least 2, so the pointers wrap by themselves
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rtn_entry_t       mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the entry on a push transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/rtn_back.sv
// Back end: walks digits, one character per cycle unless stalled or on a zero digit.
module rtn_back import rtn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  rtn_entry_t pop_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       out_last,
  output logic       out_invalid
);

  logic       busy_r, busy_nxt;
  rtn_entry_t entry_r, entry_nxt;
  place_t     place_r, place_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_symbol_r;
  logic       out_last_r, out_invalid_r;
  logic       adv;
  logic       emit, emit_last, emit_invalid;
  logic [7:0] emit_symbol;
  logic       lower_zero;
  logic       pos_final;
  pattern_t   pat;

  // Output slot is free or drains this cycle
  assign adv       = !out_valid_r || out_ready;
  assign pop_ready = !busy_r;

  // Check that every place below the current one holds zero
  always_comb begin
    lower_zero = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if (place_t'(j) < place_r && entry_r.digits[place_t'(j)] != '0) begin
        lower_zero = 1'b0;
      end
    end
  end

  assign pat       = digit_pattern(entry_r.digits[place_r]);
  assign pos_final = ({1'b0, pos_r} + 3'd1 == pat.len);

  // Step through places and symbols of the held entry
  always_comb begin
    busy_nxt     = busy_r;
    entry_nxt    = entry_r;
    place_nxt    = place_r;
    pos_nxt      = pos_r;
    emit         = 1'b0;
    emit_symbol  = CharNull;
    emit_last    = 1'b0;
    emit_invalid = 1'b0;
    if (!busy_r) begin
      if (pop_valid) begin
        entry_nxt = pop_data;
        busy_nxt  = 1'b1;
        place_nxt = PlaceThousands;
        pos_nxt   = '0;
      end
    end else if (adv) begin
      if (entry_r.invalid) begin
        emit         = 1'b1;
        emit_symbol  = CharNull;
        emit_last    = 1'b1;
        emit_invalid = 1'b1;
        busy_nxt     = 1'b0;
      end else if ({1'b0, pos_r} < pat.len) begin
        emit        = 1'b1;
        emit_symbol = place_char(place_r, pat.role[pos_r]);
        emit_last   = pos_final && lower_zero;
        if (pos_final) begin
          pos_nxt = '0;
          if (place_r == PlaceOnes) begin
            busy_nxt = 1'b0;
          end else begin
            place_nxt = place_r - 2'd1;
          end
        end else begin
          pos_nxt = pos_r + 2'd1;
        end
      end else begin
        // Skip a zero digit
        pos_nxt = '0;
        if (place_r == PlaceOnes) begin
          busy_nxt = 1'b0;
        end else begin
          place_nxt = place_r - 2'd1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload; load the output register on each new character
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    place_r <= place_nxt;
    pos_r   <= pos_nxt;
    if (emit) begin
      out_symbol_r  <= emit_symbol;
      out_last_r    <= emit_last;
      out_invalid_r <= emit_invalid;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_symbol  = out_symbol_r;
  assign out_last    = out_last_r;
  assign out_invalid = out_invalid_r;

endmodule

FILE: src/integer_to_roman_numeral_top.sv
// Top level of the integer to Roman numeral converter.
//
//  Channel | Direction | Ports                          | Contents
//  in_     | input     | tvalid tready tdata[15:0]      | value (12 bits, zero padded)
//  out_    | output    | tvalid tready tdata tlast tuser | symbol, last, invalid
//
// The front takes one value, then splits it into decimal digits (one place
// per cycle) before pushing it into the queue. The back emits one character
// per cycle while the output is ready and skips each zero digit in a step of
// its own; for long numerals the back sets the sustained rate.
// Reset is synchronous, active low, and empties the queue and output register.
// Either side may stall: the queue and output register decouple the two ends.
module integer_to_roman_numeral_top import rtn_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] value, [15:12] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] symbol
  output logic        out_tlast,
  output logic        out_tuser   // [0] invalid
);

  logic       q_push_valid, q_push_ready;
  logic       q_pop_valid, q_pop_ready;
  rtn_entry_t q_push_data, q_pop_data;

  rtn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata[11:0]),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  rtn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  rtn_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_data    (q_pop_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_symbol  (out_tdata),
    .out_last    (out_tlast),
    .out_invalid (out_tuser)
  );

  // An invalid result is a single null character that closes its numeral
  a_invalid_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == CharNull)
    else $error("invalid result not a lone null character");

  // A valid result carries one of the seven numeral characters
  a_valid_char : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata == CharM || out_tdata == CharD || out_tdata == CharC ||
      out_tdata == CharL || out_tdata == CharX || out_tdata == CharV ||
      out_tdata == CharI)
    else $error("unexpected numeral character");

  // The front takes no new value in the cycle after an input transfer
  a_front_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("front accepted back-to-back values");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the integer to Roman numeral converter.
module tb;
  import rtn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One emitted character as seen on the result channel
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       invalid;
  } glyph_t;

  // Tracks the characters still owed by the converter and checks each transfer
  class numeral_board;
    glyph_t      pending_glyphs[$];
    int unsigned weight[7] = '{1000, 500, 100, 50, 10, 5, 1};
    logic [7:0]  glyph_char[7] = '{CharM, CharD, CharC, CharL, CharX, CharV, CharI};
    int          values_seen;
    int          out_of_range;
    int          glyphs_checked;
    int          mismatches;

    // Queue the numeral of one accepted value
    function void add_numeral(value_t v);
      logic [7:0]  chars[0:15];
      int          n;
      int unsigned rem;
      int unsigned sub;
      int          step;
      glyph_t      g;
      n = 0;
      rem = 32'(v);
      values_seen++;
      if (v == 12'd0 || v >= 12'd4000) begin
        out_of_range++;
        g.symbol  = CharNull;
        g.last    = 1'b1;
        g.invalid = 1'b1;
        pending_glyphs.push_back(g);
        return;
      end
      // Greedy descent with the subtractive pairs after each symbol
      for (int i = 0; i < 7; i++) begin
        while (rem >= weight[i]) begin
          chars[n] = glyph_char[i];
          n++;
          rem -= weight[i];
        end
        step = (i % 2 == 0) ? 2 : 1;
        if (i + step < 7) begin
          sub = weight[i] - weight[i + step];
          if (rem >= sub) begin
            chars[n]     = glyph_char[i + step];
            chars[n + 1] = glyph_char[i];
            n += 2;
            rem -= sub;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        g.symbol  = chars[i];
        g.last    = (i == n - 1);
        g.invalid = 1'b0;
        pending_glyphs.push_back(g);
      end
    endfunction

    // Compare one result transfer against the oldest owed character
    function void check_glyph(logic [7:0] symbol, logic last, logic invalid);
      glyph_t want;
      glyphs_checked++;
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected character sym %h last %b inv %b", $realtime,
                   symbol, last, invalid);
        return;
      end
      want = pending_glyphs.pop_front();
      if (want.symbol !== symbol || want.last !== last || want.invalid !== invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: wrong character, want sym %h last %b inv %b, got sym %h last %b inv %b",
                   $realtime, want.symbol, want.last, want.invalid, symbol, last, invalid);
      end
    endfunction

    function int pending();
      return pending_glyphs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;  // [11:0] value, [15:12] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] symbol
  logic        out_tlast;
  logic        out_tuser;            // [0] invalid

  numeral_board board = new();

  // Receiver controls: a calm stretch forces ready, a hold request starts a long stall
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  integer_to_roman_numeral_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Note every transfer on both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_glyph(out_tdata, out_tlast, out_tuser);
      if (in_tvalid && in_tready)
        board.add_numeral(in_tdata[11:0]);
    end
  end

  // Receiver: switch among random stall patterns, honor long holds
  initial begin
    int rx_cnt;
    int rx_mode;
    rx_cnt = 0;
    rx_mode = 0;
    forever begin
      @(negedge clk);
      rx_cnt++;
      if (rx_cnt % 50 == 0)
        rx_mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_calm) begin
        out_tready <= 1'b1;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (rx_cnt % 4 == 0);
          default: out_tready <= (rx_cnt % 16 < 3);
        endcase
      end
    end
  end

  // Offer one value and hold it until the transfer; return at the next falling edge
  task automatic drive_value(input value_t v);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid with junk on the data lines; n sets the gap, zero gives none
  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {4'h0, 12'($urandom)};
      repeat (n) @(negedge clk);
    end
  endtask

  // Mostly valid values, with zero and the top range mixed in
  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 12'd0;
    if (r < 15) return 12'($urandom_range(4000, 4095));
    if (r < 30) return 12'($urandom_range(3000, 3999));
    return 12'($urandom_range(1, 3999));
  endfunction

  // Send count random values in bursts, optionally back to back
  task automatic send_random(input int count, input bit no_gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        drive_value(pick_value());
        sent++;
      end
      if (!no_gaps)
        idle_sender($urandom_range(0, 8));
    end
  endtask

  // Hold the sender until every owed character has arrived
  task automatic drain();
    idle_sender(1);
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    value_t directed[$];
    directed = '{12'd0, 12'd4000, 12'd4095, 12'd1, 12'd3999, 12'd3888, 12'd4,
                 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd10, 12'd50,
                 12'd100, 12'd500, 12'd1000, 12'd3000, 12'd444, 12'd999, 12'd1994,
                 12'd2048, 12'd2730, 12'd1365};

    // Hold reset low, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed values with random gaps
    foreach (directed[i]) begin
      drive_value(directed[i]);
      idle_sender($urandom_range(0, 3));
    end

    // Back-to-back stretch with the receiver always ready
    rx_calm = 1'b1;
    send_random(50, 1'b1);
    rx_calm = 1'b0;

    // Long receiver hold while the sender keeps offering
    hold_req = 1'b1;
    send_random(40, 1'b1);

    // Pause until everything owed has come out
    drain();

    // Bursty traffic against the receiver's own stall pattern
    send_random(110, 1'b0);

    drain();
    repeat (40) @(negedge clk);

    $display("Sent %0d values (%0d out of range), checked %0d characters",
             board.values_seen, board.out_of_range, board.glyphs_checked);
    $display("Traffic included back-to-back input, a 300-cycle output hold and random stalls");
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching characters", board.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8ms;
    $display("Timed out with %0d characters still owed", board.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
src/rtn_pkg.sv
src/rtn_front.sv
src/rtn_queue.sv
src/rtn_back.sv
src/integer_to_roman_numeral_top.sv
sim/tb.sv
